@@ design/assert_macros.svh @@
// Concurrent check helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ design/lts_pkg.sv @@
package lts_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UB_RD,
    ST_UB_CHK,
    ST_BLK,
    ST_BLK_DIV,
    ST_BLK_PUT,
    ST_DRAW,
    ST_DR_DIV,
    ST_DR_RD,
    ST_DR_CHK,
    ST_SH_RD,
    ST_SH_WR,
    ST_EMIT
  } state_t;

  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_UNBLOCK = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  localparam logic [1:0] RSN_TICK  = 2'd0;
  localparam logic [1:0] RSN_BLOCK = 2'd1;
  localparam logic [1:0] RSN_EXIT  = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 1'b1;

  localparam logic [31:0] LFSR_MASK   = 32'h8020_0003;
  localparam logic [7:0]  QUANTUM_RST = 8'd10;
  localparam logic [31:0] SEED_RST    = 32'd1;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] tickets;
  } entry_t;

  // Right-shifting Galois LFSR, one step.
  function automatic logic [31:0] lfsr_step(input logic [31:0] s);
    return (s >> 1) ^ (s[0] ? LFSR_MASK : 32'd0);
  endfunction

endpackage

@@ design/lts_ifs.sv @@
interface lts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] task_id;
  logic [1:0] tick_reason;
  modport source (output valid, req_type, task_id, tick_reason, input ready);
  modport sink (input valid, req_type, task_id, tick_reason, output ready);
endinterface

interface lts_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_task;
  logic       is_idle;
  modport source (output valid, run_task, is_idle, input ready);
  modport sink (input valid, run_task, is_idle, output ready);
endinterface

interface lts_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lts_pkg::CFG_IDX_W-1:0]  index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ design/lottery_task_scheduler_unit.sv @@
// Channel | Dir | Payload                          | Accepted when
// req     | in  | req_type, task_id, tick_reason   | req.valid && req.ready
// res     | out | run_task, is_idle                | res.valid && res.ready
// cfg     | in  | index, data                      | cfg.valid && cfg.ready
//
// One item at a time; req.ready and cfg.ready are high only between items.
// A load is written in the idle state; an unblock reads and checks each blocked entry
// searched and moves later entries up. A draw runs the shared divider, then walks the
// ready entries and moves later ones up; a block may first run the divider for the reward.
// Reset is synchronous; the result register holds until res.ready is seen.
`include "assert_macros.svh"

module lottery_task_scheduler_unit #(
  parameter int MAX_TASKS = 32
) (
  input  logic       clk,
  input  logic       rst,
  lts_req_if.sink    req,
  lts_res_if.source  res,
  lts_cfg_if.sink    cfg
);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int TW = $clog2(MAX_TASKS * 255 + 1);

  lts_pkg::state_t state, state_next;

  lts_pkg::entry_t ready_mem [MAX_TASKS];
  lts_pkg::entry_t blocked_mem [MAX_TASKS];
  lts_pkg::entry_t rdata_r, rdata_b, wdata_r, wdata_b;
  logic [IW-1:0]   raddr, waddr_r, waddr_b;
  logic            we_r, we_b;

  logic [CW-1:0] ready_count, blocked_count;
  logic [TW-1:0] ticket_total, sum, win;
  logic [IW-1:0] idx;
  logic [7:0]    running_id, ticks_left, quantum, reward, id_q;
  logic          running_valid, sh_blocked;
  logic [31:0]   lfsr;
  logic          res_valid, res_idle;
  logic [7:0]    res_task;

  logic          div_start, div_busy, div_done;
  logic [31:0]   div_num, div_quot;
  logic [TW-1:0] div_den, div_rem;

  logic          accept, tick_acc, r_room, b_room, is_exit, is_block, requeue;
  logic [7:0]    tl_dec, used;
  logic [TW:0]   sum_try;
  logic          hit, last, more;
  logic [CW-1:0] idx_ext, sh_count;

  assign accept   = req.valid && req.ready;
  assign tick_acc = accept && req.req_type == lts_pkg::REQ_TICK;
  assign r_room   = ready_count < CW'(MAX_TASKS);
  assign b_room   = blocked_count < CW'(MAX_TASKS);
  assign is_exit  = running_valid && req.tick_reason == lts_pkg::RSN_EXIT;
  assign is_block = running_valid && req.tick_reason == lts_pkg::RSN_BLOCK;
  assign requeue  = running_valid && !is_exit && !is_block && ticks_left == 8'd1;
  assign tl_dec   = (ticks_left != 8'd0) ? ticks_left - 8'd1 : ticks_left;
  assign used     = quantum - ticks_left;
  assign sum_try  = {1'b0, sum} + (TW + 1)'(rdata_r.tickets);
  assign hit      = sum_try > {1'b0, win};
  assign idx_ext  = CW'(idx);
  assign last     = idx_ext + CW'(1) == ready_count;
  assign sh_count = sh_blocked ? blocked_count : ready_count;
  // During a shift, idx is the slot being refilled; more slots follow if idx+2 < count.
  assign more     = idx_ext + CW'(2) < sh_count;

  assign cfg.ready = state == lts_pkg::ST_IDLE;
  assign res.valid    = res_valid;
  assign res.run_task = res_task;
  assign res.is_idle  = res_idle;

  lts_div #(.NW(32), .DW(TW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    if (we_r) begin
      ready_mem[waddr_r] <= wdata_r;
    end
    rdata_r <= ready_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      blocked_mem[waddr_b] <= wdata_b;
    end
    rdata_b <= blocked_mem[raddr];
  end

  always_comb begin
    state_next = state;
    case (state)
      lts_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.req_type)
            lts_pkg::REQ_UNBLOCK: begin
              if (blocked_count != '0) state_next = lts_pkg::ST_UB_RD;
            end
            lts_pkg::REQ_TICK: begin
              if (is_exit) state_next = lts_pkg::ST_DRAW;
              else if (is_block) state_next = lts_pkg::ST_BLK;
              else if (requeue) state_next = r_room ? lts_pkg::ST_DRAW : lts_pkg::ST_EMIT;
              else if (!running_valid && ready_count != '0) state_next = lts_pkg::ST_DRAW;
              else state_next = lts_pkg::ST_EMIT;
            end
            default: state_next = lts_pkg::ST_IDLE;
          endcase
        end
      end
      lts_pkg::ST_UB_RD: state_next = lts_pkg::ST_UB_CHK;
      lts_pkg::ST_UB_CHK: begin
        if (rdata_b.id == id_q) begin
          if (!r_room) state_next = lts_pkg::ST_IDLE;
          else if (idx_ext + CW'(1) < blocked_count) state_next = lts_pkg::ST_SH_RD;
          else state_next = lts_pkg::ST_IDLE;
        end else if (idx_ext + CW'(1) < blocked_count) begin
          state_next = lts_pkg::ST_UB_RD;
        end else begin
          state_next = lts_pkg::ST_IDLE;
        end
      end
      lts_pkg::ST_BLK: begin
        state_next = (quantum > ticks_left) ? lts_pkg::ST_BLK_DIV : lts_pkg::ST_BLK_PUT;
      end
      lts_pkg::ST_BLK_DIV: begin
        if (div_done) state_next = lts_pkg::ST_BLK_PUT;
      end
      lts_pkg::ST_BLK_PUT: state_next = lts_pkg::ST_DRAW;
      lts_pkg::ST_DRAW: begin
        if (ready_count == '0 || ticket_total == '0) state_next = lts_pkg::ST_EMIT;
        else state_next = lts_pkg::ST_DR_DIV;
      end
      lts_pkg::ST_DR_DIV: begin
        if (div_done) state_next = lts_pkg::ST_DR_RD;
      end
      lts_pkg::ST_DR_RD: state_next = lts_pkg::ST_DR_CHK;
      lts_pkg::ST_DR_CHK: begin
        if (hit || last) state_next = last ? lts_pkg::ST_EMIT : lts_pkg::ST_SH_RD;
        else state_next = lts_pkg::ST_DR_RD;
      end
      lts_pkg::ST_SH_RD: state_next = lts_pkg::ST_SH_WR;
      lts_pkg::ST_SH_WR: begin
        if (more) state_next = lts_pkg::ST_SH_RD;
        else state_next = sh_blocked ? lts_pkg::ST_IDLE : lts_pkg::ST_EMIT;
      end
      lts_pkg::ST_EMIT: begin
        if (!res_valid || res.ready) state_next = lts_pkg::ST_IDLE;
      end
      default: state_next = lts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = state == lts_pkg::ST_IDLE;
    raddr     = (state == lts_pkg::ST_SH_RD) ? IW'(idx_ext + CW'(1)) : idx;
    we_r      = 1'b0;
    waddr_r   = IW'(ready_count);
    wdata_r   = '{id: req.task_id, tickets: 8'd1};
    we_b      = 1'b0;
    waddr_b   = IW'(blocked_count);
    wdata_b   = '{id: running_id, tickets: reward};
    div_start = 1'b0;
    div_num   = lts_pkg::lfsr_step(lfsr);
    div_den   = ticket_total;
    case (state)
      lts_pkg::ST_IDLE: begin
        if (accept && req.req_type == lts_pkg::REQ_LOAD && r_room) begin
          we_r = 1'b1;
        end
        if (accept && req.req_type == lts_pkg::REQ_TICK && requeue && r_room) begin
          we_r    = 1'b1;
          wdata_r = '{id: running_id, tickets: 8'd1};
        end
      end
      lts_pkg::ST_UB_CHK: begin
        if (rdata_b.id == id_q && r_room) begin
          we_r    = 1'b1;
          wdata_r = '{id: id_q, tickets: rdata_b.tickets};
        end
      end
      lts_pkg::ST_BLK: begin
        if (quantum > ticks_left) begin
          div_start = 1'b1;
          div_num   = {24'd0, quantum};
          div_den   = TW'(used);
        end
      end
      lts_pkg::ST_BLK_PUT: begin
        we_b = b_room;
      end
      lts_pkg::ST_DRAW: begin
        div_start = ready_count != '0 && ticket_total != '0;
      end
      lts_pkg::ST_SH_WR: begin
        if (sh_blocked) begin
          we_b    = 1'b1;
          waddr_b = idx;
          wdata_b = rdata_b;
        end else begin
          we_r    = 1'b1;
          waddr_r = idx;
          wdata_r = rdata_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The result register fills in EMIT and empties when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == lts_pkg::ST_EMIT && (!res_valid || res.ready)) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_count   <= '0;
      blocked_count <= '0;
      ticket_total  <= '0;
      running_id    <= '0;
      running_valid <= 1'b0;
      ticks_left    <= lts_pkg::QUANTUM_RST;
      quantum       <= lts_pkg::QUANTUM_RST;
      lfsr          <= lts_pkg::SEED_RST;
      sh_blocked    <= 1'b0;
      idx           <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == lts_pkg::CFG_QUANTUM) quantum <= cfg.data[7:0];
        if (cfg.index == lts_pkg::CFG_SEED) lfsr <= (cfg.data == '0) ? 32'd1 : cfg.data;
      end
      case (state)
        lts_pkg::ST_IDLE: begin
          if (accept) begin
            id_q <= req.task_id;
            idx  <= '0;
            case (req.req_type)
              lts_pkg::REQ_LOAD: begin
                if (r_room) begin
                  ready_count  <= ready_count + CW'(1);
                  ticket_total <= ticket_total + TW'(1);
                end
              end
              lts_pkg::REQ_TICK: begin
                if (is_block) begin
                  ticks_left <= tl_dec;
                end else if (!is_exit && requeue) begin
                  if (r_room) begin
                    ready_count  <= ready_count + CW'(1);
                    ticket_total <= ticket_total + TW'(1);
                  end else begin
                    ticks_left <= quantum;
                  end
                end else if (!is_exit && !(!running_valid && ready_count != '0)) begin
                  ticks_left <= tl_dec;
                end
              end
              default: begin
              end
            endcase
          end
        end
        lts_pkg::ST_UB_CHK: begin
          if (rdata_b.id == id_q) begin
            if (r_room) begin
              ready_count  <= ready_count + CW'(1);
              ticket_total <= ticket_total + TW'(rdata_b.tickets);
              sh_blocked   <= 1'b1;
              if (!(idx_ext + CW'(1) < blocked_count)) blocked_count <= blocked_count - CW'(1);
            end
          end else begin
            idx <= idx + IW'(1);
          end
        end
        lts_pkg::ST_BLK: begin
          reward <= 8'd1;
        end
        lts_pkg::ST_BLK_DIV: begin
          if (div_done) reward <= (div_quot[7:0] == 8'd0) ? 8'd1 : div_quot[7:0];
        end
        lts_pkg::ST_BLK_PUT: begin
          if (b_room) blocked_count <= blocked_count + CW'(1);
        end
        lts_pkg::ST_DRAW: begin
          running_valid <= 1'b0;
          running_id    <= '0;
          if (ready_count != '0 && ticket_total != '0) lfsr <= lts_pkg::lfsr_step(lfsr);
        end
        lts_pkg::ST_DR_DIV: begin
          win <= div_rem;
          sum <= '0;
          idx <= '0;
        end
        lts_pkg::ST_DR_CHK: begin
          if (hit || last) begin
            running_id    <= rdata_r.id;
            running_valid <= 1'b1;
            ticket_total  <= ticket_total - TW'(rdata_r.tickets);
            ticks_left    <= quantum;
            sh_blocked    <= 1'b0;
            if (last) ready_count <= ready_count - CW'(1);
          end else begin
            sum <= sum_try[TW-1:0];
            idx <= idx + IW'(1);
          end
        end
        lts_pkg::ST_SH_WR: begin
          if (more) begin
            idx <= idx + IW'(1);
          end else if (sh_blocked) begin
            blocked_count <= blocked_count - CW'(1);
          end else begin
            ready_count <= ready_count - CW'(1);
          end
        end
        lts_pkg::ST_EMIT: begin
          if (!res_valid || res.ready) begin
            res_task  <= running_valid ? running_id : 8'd0;
            res_idle  <= !running_valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_tick_busy, clk, rst, tick_acc, !req.ready, "tick item did not leave idle")
  `ASSERT_IMPLIES(a_empty_total, clk, rst, ready_count == '0, ticket_total == '0, "stray tickets")
  `ASSERT_IMPLIES(a_idle_zero, clk, rst, res.valid && res.is_idle, res.run_task == 8'd0, "idle id")
  `ASSERT_NEXT(a_div_runs, clk, rst, div_start, div_busy, "divider did not start")

endmodule

@@ design/lts_div.sv @@
// Restoring divider, one quotient bit per cycle.
module lts_div #(
  parameter int NW = 32,
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);
  localparam int CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   qsh;
  logic [DW-1:0]   r;
  logic [DW-1:0]   d;
  logic [DW:0]     trial;
  logic            fits;

  assign trial = {r, qsh[NW-1]};
  assign fits  = trial >= {1'b0, d};
  assign busy  = cnt != '0;
  assign quot  = qsh;
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qsh <= num;
      r   <= '0;
      d   <= den;
    end else if (busy) begin
      qsh <= {qsh[NW-2:0], fits};
      r   <= fits ? DW'(trial - {1'b0, d}) : trial[DW-1:0];
    end
  end
endmodule
